// ----- design/fmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fmpc_pkg: shared types and constants of the first-match classifier
// Rule layout, field codes, control/status bundles and the port compare.
// ----------------------------------------------------------------------------
package fmpc_pkg;

   // table geometry
   localparam int MAX_RULES = 64;
   localparam int RULE_AW   = 6;   // address bits of the rule table
   localparam int COUNT_W   = 7;   // rule_count register width

   // field codes
   localparam logic       OP_WRITE    = 1'b0;
   localparam logic       OP_CLASSIFY = 1'b1;
   localparam logic [1:0] DIR_ANY     = 2'd2;
   localparam logic [1:0] PROTO_ICMP  = 2'd0;
   localparam logic [1:0] PROTO_UDP   = 2'd2;
   localparam logic [1:0] PROTO_ANY   = 2'd3;
   localparam logic [1:0] ACK_ANY     = 2'd2;
   localparam logic [15:0] PORT_ANY   = 16'd0;
   localparam logic [15:0] PORT_HIGH  = 16'd1023;

   // configuration register indexes
   localparam logic REG_TABLE_ACTIVE = 1'b0;
   localparam logic REG_RULE_COUNT   = 1'b1;

   typedef enum logic [1:0] {
      REASON_MATCH     = 2'd0,
      REASON_NO_MATCH  = 2'd1,
      REASON_INACTIVE  = 2'd2,
      REASON_WRITE_DONE = 2'd3
   } reason_type;

   typedef enum logic [1:0] {
      POST_WRITE,
      POST_INACTIVE,
      POST_NO_MATCH,
      POST_HIT
   } post_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]  direction;
      logic [31:0] src_ip;
      logic [31:0] src_mask;
      logic [31:0] dst_ip;
      logic [31:0] dst_mask;
      logic [1:0]  protocol;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
      logic [1:0]  ack;
      logic        action;
   } rule_type;

   typedef struct packed {
      logic [1:0]  direction;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [1:0]  protocol;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
      logic [1:0]  ack;
   } header_type;

   typedef struct packed {
      logic               table_active;
      logic [COUNT_W-1:0] rule_count;
   } cfg_type;

   typedef struct packed {
      logic          write;      // store the rule on the request ports
      logic          load;       // latch the header and restart the scan
      logic          step;       // scan one more rule
      logic          post;       // register a result transaction
      post_kind_type post_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic active;
      logic count_zero;
      logic hit;         // registered rule matches the header
      logic rvalid;      // a rule read is waiting for compare
      logic issue_done;  // every rule in use has been read
   } dp_status_type;

   // rule port 0 is any, 1023 is 1023 or any port above it
   function automatic logic port_ok(input logic [15:0] rport,
                                    input logic [15:0] pkt_port);
      port_ok = (rport == PORT_ANY)
             || ((rport == PORT_HIGH) && (pkt_port > PORT_HIGH))
             || (rport == pkt_port);
   endfunction

endpackage

// ----- design/fmpc_csr.sv -----
// ----------------------------------------------------------------------------
// fmpc_csr: configuration registers
// APB-style register file holding table_active and rule_count.
// ----------------------------------------------------------------------------
module fmpc_csr
   import fmpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic               table_active_ff, table_active_in;
   logic [COUNT_W-1:0] rule_count_ff, rule_count_in;
   logic               wr_en;
   logic               reg_sel;

   // decode one register per word
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // update the addressed register
   always_comb begin
      table_active_in = table_active_ff;
      rule_count_in   = rule_count_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TABLE_ACTIVE: table_active_in = pwdata[0];
            REG_RULE_COUNT:   rule_count_in   = pwdata[COUNT_W-1:0];
            default:          table_active_in = table_active_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_active_ff <= 1'b0;
         rule_count_ff   <= '0;
      end else begin
         table_active_ff <= table_active_in;
         rule_count_ff   <= rule_count_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         REG_TABLE_ACTIVE: prdata = {31'd0, table_active_ff};
         REG_RULE_COUNT:   prdata = {{(32-COUNT_W){1'b0}}, rule_count_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg.table_active = table_active_ff;
   assign cfg.rule_count   = rule_count_ff;

endmodule

// ----- design/fmpc_datapath.sv -----
// ----------------------------------------------------------------------------
// fmpc_datapath: rule table, scan counter, rule compare and result register
// One rule is read per cycle; the registered rule is compared next cycle.
// ----------------------------------------------------------------------------
module fmpc_datapath
   import fmpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [5:0]    req_index,
   input  logic [1:0]    req_direction,
   input  logic [31:0]   req_src_ip,
   input  logic [31:0]   req_src_mask,
   input  logic [31:0]   req_dst_ip,
   input  logic [31:0]   req_dst_mask,
   input  logic [1:0]    req_protocol,
   input  logic [15:0]   req_src_port,
   input  logic [15:0]   req_dst_port,
   input  logic [1:0]    req_ack,
   input  logic          req_action,
   output logic          rsp_valid,
   output logic          rsp_verdict,
   output logic [1:0]    rsp_reason,
   output logic [5:0]    rsp_matched_rule
);

   rule_type             rule_mem [MAX_RULES];
   rule_type             rdata_ff;
   header_type           hdr_ff;
   rule_type             wr_rule;
   logic [COUNT_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0]   count_eff;
   logic [RULE_AW-1:0]   ridx_ff;
   logic                 rvalid_ff, rvalid_in;
   logic                 issue;
   logic                 issue_done;
   logic                 match;
   logic                 dir_ok, src_ok, dst_ok, prot_ok, ports_ok, ack_ok;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 verdict_ff, verdict_in;
   reason_type           reason_ff, reason_in;
   logic [5:0]           matched_ff, matched_in;

   // clamp the rule count to the table depth
   assign count_eff  = (cfg.rule_count > COUNT_W'(MAX_RULES)) ?
                       COUNT_W'(MAX_RULES) : cfg.rule_count;
   assign issue_done = (idx_ff == count_eff);
   assign issue      = cmd.step && !issue_done;

   // store a rule
   assign wr_rule = '{direction: req_direction, src_ip: req_src_ip,
                      src_mask: req_src_mask, dst_ip: req_dst_ip,
                      dst_mask: req_dst_mask, protocol: req_protocol,
                      l4_src: req_src_port, l4_dst: req_dst_port,
                      ack: req_ack, action: req_action};

   always_ff @(posedge clock) begin
      if (cmd.write && ({1'b0, req_index} < COUNT_W'(MAX_RULES))) begin
         rule_mem[req_index[RULE_AW-1:0]] <= wr_rule;
      end
   end

   // read one rule per cycle while scanning
   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= rule_mem[idx_ff[RULE_AW-1:0]];
         ridx_ff  <= idx_ff[RULE_AW-1:0];
      end
   end

   // latch the packet header
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hdr_ff <= '{direction: req_direction, src_ip: req_src_ip,
                     dst_ip: req_dst_ip, protocol: req_protocol,
                     l4_src: req_src_port, l4_dst: req_dst_port,
                     ack: req_ack};
      end
   end

   // advance the scan index
   always_comb begin
      idx_in    = idx_ff;
      rvalid_in = issue;
      if (cmd.load) begin
         idx_in    = '0;
         rvalid_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // compare the registered rule against the header
   assign dir_ok   = (rdata_ff.direction == DIR_ANY)
                  || (rdata_ff.direction == hdr_ff.direction);
   assign src_ok   = (rdata_ff.src_ip == 32'd0)
                  || (((rdata_ff.src_ip ^ hdr_ff.src_ip) & rdata_ff.src_mask) == 32'd0);
   assign dst_ok   = (rdata_ff.dst_ip == 32'd0)
                  || (((rdata_ff.dst_ip ^ hdr_ff.dst_ip) & rdata_ff.dst_mask) == 32'd0);
   assign prot_ok  = (rdata_ff.protocol == PROTO_ANY)
                  || (rdata_ff.protocol == hdr_ff.protocol);
   assign ports_ok = port_ok(rdata_ff.l4_src, hdr_ff.l4_src)
                  && port_ok(rdata_ff.l4_dst, hdr_ff.l4_dst);
   assign ack_ok   = (rdata_ff.ack == ACK_ANY) || (rdata_ff.ack == hdr_ff.ack);

   // ICMP skips ports and ack, UDP skips ack
   assign match = dir_ok && src_ok && dst_ok && prot_ok
               && ((hdr_ff.protocol == PROTO_ICMP)
                   || (ports_ok && ((hdr_ff.protocol == PROTO_UDP) || ack_ok)));

   assign status.active     = cfg.table_active;
   assign status.count_zero = (count_eff == '0);
   assign status.hit        = rvalid_ff && match;
   assign status.rvalid     = rvalid_ff;
   assign status.issue_done = issue_done;

   // form the result transaction
   always_comb begin
      rsp_valid_in = cmd.post;
      verdict_in   = 1'b0;
      reason_in    = REASON_WRITE_DONE;
      matched_in   = '0;
      case (cmd.post_kind)
         POST_WRITE:    reason_in = REASON_WRITE_DONE;
         POST_INACTIVE: begin
            verdict_in = 1'b1;
            reason_in  = REASON_INACTIVE;
         end
         POST_NO_MATCH: reason_in = REASON_NO_MATCH;
         POST_HIT: begin
            verdict_in = rdata_ff.action;
            reason_in  = REASON_MATCH;
            matched_in = 6'(ridx_ff);
         end
         default:       reason_in = REASON_WRITE_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         verdict_ff <= verdict_in;
         reason_ff  <= reason_in;
         matched_ff <= matched_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_reason       = reason_ff;
   assign rsp_matched_rule = matched_ff;

`ifndef SYNTHESIS
   a_post_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.post |=> rsp_valid_ff)
      else $error("posted result did not appear on the response strobe");

   a_match_from_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (reason_ff == REASON_MATCH)) |-> $past(rvalid_ff && match))
      else $error("matched result without a rule hit");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && rvalid_ff) |-> ({1'b0, ridx_ff} < count_eff))
      else $error("scan read a rule beyond the rule count");
`endif

endmodule

// ----- design/fmpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fmpc_ctrl: controller of the classifier
// Accepts transactions, sequences the rule scan and posts results.
// ----------------------------------------------------------------------------
module fmpc_ctrl
   import fmpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_operation,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.post_kind = POST_WRITE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_WRITE) begin
                  cmd.write     = 1'b1;
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_WRITE;
               end else if (!status.active) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_INACTIVE;
               end else if (status.count_zero) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_NO_MATCH;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.hit) begin
               cmd.step      = 1'b0;
               cmd.post      = 1'b1;
               cmd.post_kind = POST_HIT;
               state_in      = ST_IDLE;
            end else if (status.rvalid && status.issue_done) begin
               cmd.post      = 1'b1;
               cmd.post_kind = POST_NO_MATCH;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && status.hit) |=> (state_ff == ST_IDLE))
      else $error("scan continued after a rule hit");

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_CLASSIFY) && status.active && !status.count_zero)
      |=> (state_ff == ST_SCAN) && !status.rvalid)
      else $error("classify transaction did not start a clean scan");
`endif

endmodule

// ----- design/first_match_packet_rule_classifier_core.sv -----
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier_core: five-tuple first-match ACL engine
// Stores access rules and classifies packet headers against them.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* and raise start; a transaction is taken at a clock
//   edge with start high and busy low. req_operation 0 writes the rule on
//   req_* into slot req_index, 1 classifies the header on req_*.
//   Response: one transaction per request, shown on rsp_* for a single
//   cycle while rsp_valid is high. The receiver cannot stall; it must take
//   each response in the cycle it appears.
//   Configuration: APB-style port, table_active at byte 0, rule_count at
//   byte 4; write only while the block is idle.
// Timing:
//   A write, an inactive-table classify or a zero rule count answers on the
//   cycle after acceptance, and busy stays low, so one such transaction per
//   cycle is sustained. A scan reads one rule per cycle from the rule table
//   into a read register and compares it with the header. A hit on rule k
//   answers with rule k; a miss answers once rule_count rules are read
//   (rule_count capped at 64). busy stays high until the result is posted.
// Reset: clears the registers, the controller and the response strobe; the
//   rule table holds no defined contents until each slot is written.
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier_core
   import fmpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [5:0]  req_index,
   input  logic [1:0]  req_direction,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_src_mask,
   input  logic [31:0] req_dst_ip,
   input  logic [31:0] req_dst_mask,
   input  logic [1:0]  req_protocol,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [1:0]  req_ack,
   input  logic        req_action,
   // response channel
   output logic        rsp_valid,
   output logic        rsp_verdict,
   output logic [1:0]  rsp_reason,
   output logic [5:0]  rsp_matched_rule,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // configuration registers
   fmpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // controller
   fmpc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   // datapath
   fmpc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_index        (req_index),
      .req_direction    (req_direction),
      .req_src_ip       (req_src_ip),
      .req_src_mask     (req_src_mask),
      .req_dst_ip       (req_dst_ip),
      .req_dst_mask     (req_dst_mask),
      .req_protocol     (req_protocol),
      .req_src_port     (req_src_port),
      .req_dst_port     (req_dst_port),
      .req_ack          (req_ack),
      .req_action       (req_action),
      .rsp_valid        (rsp_valid),
      .rsp_verdict      (rsp_verdict),
      .rsp_reason       (rsp_reason),
      .rsp_matched_rule (rsp_matched_rule)
   );

endmodule

// ----- tb/sv/first_match_packet_rule_classifier_core_tb.sv -----
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier_core_tb: regression bench for the ACL core
// Fills the rule table and sweeps the table_active and rule_count settings,
// the extremes among them. Drives rule writes, classifications built from
// stored rules and random headers, with random gaps. A scoreboard predicts
// each verdict and checks every response transaction in order.
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier_core_tb;
   import fmpc_pkg::*;

   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          RANDOM_ITEMS = 1700;
   localparam int          PHASE_ITEMS  = 120;
   localparam logic [1:0]  DIR_IN       = 2'd0;
   localparam logic [1:0]  DIR_OUT      = 2'd1;
   localparam logic [1:0]  PROTO_TCP    = 2'd1;
   localparam logic [1:0]  ACK_CLEAR    = 2'd0;
   localparam logic [1:0]  ACK_SET      = 2'd1;
   localparam logic        ACT_DROP     = 1'b0;
   localparam logic        ACT_ACCEPT   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [5:0]  index;
      logic [1:0]  direction;
      logic [31:0] src_ip;
      logic [31:0] src_mask;
      logic [31:0] dst_ip;
      logic [31:0] dst_mask;
      logic [1:0]  protocol;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
      logic [1:0]  ack;
      logic        action;
   } acl_req_t;

   typedef struct packed {
      logic       verdict;
      reason_type reason;
      logic [5:0] matched;
   } acl_verdict_t;

   // Predict verdicts from a private rule table and check them in order
   class verdict_scoreboard;
      acl_req_t     rule_copy[MAX_RULES];
      logic         active;
      logic [6:0]   count;
      acl_verdict_t pending_q[$];
      int           mismatches;
      int           n_write, n_classify, n_hit, n_miss, n_inactive;

      function new();
         active     = 1'b0;
         count      = '0;
         mismatches = 0;
         n_write    = 0;
         n_classify = 0;
         n_hit      = 0;
         n_miss     = 0;
         n_inactive = 0;
      endfunction

      function void set_register(logic reg_idx, logic [31:0] value);
         if (reg_idx == REG_TABLE_ACTIVE) active = value[0];
         else count = value[6:0];
      endfunction

      function bit port_covers(logic [15:0] rport, logic [15:0] pport);
         if (rport == PORT_ANY) return 1'b1;
         if (rport == PORT_HIGH && pport > PORT_HIGH) return 1'b1;
         return rport == pport;
      endfunction

      function bit rule_matches(acl_req_t r, acl_req_t p);
         if (r.direction != DIR_ANY && r.direction != p.direction) return 1'b0;
         if (r.src_ip != 0 && (r.src_ip & r.src_mask) != (p.src_ip & r.src_mask))
            return 1'b0;
         if (r.dst_ip != 0 && (r.dst_ip & r.dst_mask) != (p.dst_ip & r.dst_mask))
            return 1'b0;
         if (r.protocol != PROTO_ANY && r.protocol != p.protocol) return 1'b0;
         // ICMP skips ports and ack, UDP skips ack
         if (p.protocol == PROTO_ICMP) return 1'b1;
         if (!port_covers(r.l4_src, p.l4_src)) return 1'b0;
         if (!port_covers(r.l4_dst, p.l4_dst)) return 1'b0;
         if (p.protocol == PROTO_UDP) return 1'b1;
         return r.ack == ACK_ANY || r.ack == p.ack;
      endfunction

      // Compute the verdict and apply rule writes to the private table
      function acl_verdict_t predict(acl_req_t t);
         acl_verdict_t v;
         int           scan_len;
         bit           found;
         v.verdict = 1'b0;
         v.reason  = REASON_NO_MATCH;
         v.matched = '0;
         found     = 1'b0;
         if (t.operation == OP_WRITE) begin
            if (t.index < MAX_RULES) rule_copy[t.index] = t;
            v.reason = REASON_WRITE_DONE;
         end else if (!active) begin
            v.verdict = 1'b1;
            v.reason  = REASON_INACTIVE;
         end else begin
            scan_len = (count > MAX_RULES) ? MAX_RULES : count;
            for (int i = 0; i < scan_len && !found; i++) begin
               if (rule_matches(rule_copy[i], t)) begin
                  found     = 1'b1;
                  v.verdict = rule_copy[i].action;
                  v.reason  = REASON_MATCH;
                  v.matched = i[5:0];
               end
            end
         end
         return v;
      endfunction

      function void note_request(acl_req_t t);
         acl_verdict_t v;
         v = predict(t);
         pending_q.push_back(v);
         case (v.reason)
            REASON_WRITE_DONE: n_write++;
            REASON_MATCH:      n_hit++;
            REASON_NO_MATCH:   n_miss++;
            default:           n_inactive++;
         endcase
         if (t.operation == OP_CLASSIFY) n_classify++;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR: %s", msg);
      endfunction

      function void check_response(logic verdict, logic [1:0] reason, logic [5:0] matched);
         acl_verdict_t want;
         if (pending_q.size() == 0) begin
            flag($sformatf("response with nothing pending: verdict %0d reason %0d rule %0d",
                           verdict, reason, matched));
            return;
         end
         want = pending_q.pop_front();
         if (verdict !== want.verdict || reason !== want.reason || matched !== want.matched)
            flag($sformatf("verdict/reason/rule expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           want.verdict, want.reason, want.matched,
                           verdict, reason, matched));
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = 1'b0;
   logic [5:0]  req_index = '0;
   logic [1:0]  req_direction = '0;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_src_mask = '0;
   logic [31:0] req_dst_ip = '0;
   logic [31:0] req_dst_mask = '0;
   logic [1:0]  req_protocol = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic [1:0]  req_ack = '0;
   logic        req_action = 1'b0;
   logic        rsp_valid;
   logic        rsp_verdict;
   logic [1:0]  rsp_reason;
   logic [5:0]  rsp_matched_rule;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   verdict_scoreboard sb = new();
   int                cycles = 0;
   int                settings_seen = 0;

   first_match_packet_rule_classifier_core dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_index(req_index),
      .req_direction(req_direction),
      .req_src_ip(req_src_ip), .req_src_mask(req_src_mask),
      .req_dst_ip(req_dst_ip), .req_dst_mask(req_dst_mask),
      .req_protocol(req_protocol),
      .req_src_port(req_src_port), .req_dst_port(req_dst_port),
      .req_ack(req_ack), .req_action(req_action),
      .rsp_valid(rsp_valid), .rsp_verdict(rsp_verdict),
      .rsp_reason(rsp_reason), .rsp_matched_rule(rsp_matched_rule),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Check every response transaction at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_response(rsp_verdict, rsp_reason, rsp_matched_rule);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles, sb.outstanding());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] prefix_mask(int len);
      return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
   endfunction

   function automatic logic [15:0] rand_rule_port();
      case ($urandom_range(0, 3))
         0:       return PORT_ANY;
         1:       return PORT_HIGH;
         2:       return 16'($urandom_range(1, 1100));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic acl_req_t rand_rule(logic [5:0] slot);
      acl_req_t t;
      t = '0;
      t.operation = OP_WRITE;
      t.index     = slot;
      t.direction = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      t.src_ip    = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
      t.src_mask  = ($urandom_range(0, 7) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
      t.dst_ip    = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
      t.dst_mask  = ($urandom_range(0, 7) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
      t.protocol  = 2'($urandom_range(0, 3));
      t.l4_src    = rand_rule_port();
      t.l4_dst    = rand_rule_port();
      t.ack       = ($urandom_range(0, 14) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      t.action    = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic logic [15:0] port_for(logic [15:0] rport);
      if (rport == PORT_ANY) return 16'($urandom);
      if (rport == PORT_HIGH)
         return ($urandom_range(0, 7) == 0) ? PORT_HIGH : 16'($urandom_range(1024, 65535));
      return rport;
   endfunction

   // Build a header that the given rule should accept, then maybe break it
   function automatic acl_req_t packet_from_rule(acl_req_t r);
      acl_req_t p;
      p = '0;
      p.operation = OP_CLASSIFY;
      p.index     = 6'($urandom);
      p.src_mask  = $urandom;
      p.dst_mask  = $urandom;
      p.action    = 1'($urandom_range(0, 1));
      p.direction = (r.direction >= DIR_ANY) ? 2'($urandom_range(0, 1)) : r.direction;
      p.src_ip    = (r.src_ip & r.src_mask) | ($urandom & ~r.src_mask);
      p.dst_ip    = (r.dst_ip & r.dst_mask) | ($urandom & ~r.dst_mask);
      if (r.protocol == PROTO_ANY)
         p.protocol = ($urandom_range(0, 9) == 0) ? PROTO_ANY : 2'($urandom_range(0, 2));
      else
         p.protocol = r.protocol;
      p.l4_src    = port_for(r.l4_src);
      p.l4_dst    = port_for(r.l4_dst);
      p.ack       = (r.ack >= ACK_ANY) ? 2'($urandom_range(0, 1)) : r.ack;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0: p.direction ^= 2'(1 << $urandom_range(0, 1));
            1: p.src_ip    ^= 32'(1) << $urandom_range(0, 31);
            2: p.dst_ip    ^= 32'(1) << $urandom_range(0, 31);
            3: p.protocol  ^= 2'(1 << $urandom_range(0, 1));
            4: p.l4_dst    ^= 16'(1) << $urandom_range(0, 15);
            default: p.ack ^= 2'(1 << $urandom_range(0, 1));
         endcase
      end
      return p;
   endfunction

   function automatic acl_req_t mk_rule(logic [5:0] slot, logic [1:0] dir,
                                        logic [31:0] sip, logic [31:0] smask,
                                        logic [31:0] dip, logic [31:0] dmask,
                                        logic [1:0] proto, logic [15:0] sport,
                                        logic [15:0] dport, logic [1:0] ack, logic act);
      return '{OP_WRITE, slot, dir, sip, smask, dip, dmask, proto, sport, dport, ack, act};
   endfunction

   function automatic acl_req_t mk_pkt(logic [1:0] dir, logic [31:0] sip, logic [31:0] dip,
                                       logic [1:0] proto, logic [15:0] sport,
                                       logic [15:0] dport, logic [1:0] ack);
      return '{OP_CLASSIFY, 6'($urandom), dir, sip, 32'($urandom), dip, 32'($urandom),
               proto, sport, dport, ack, 1'($urandom)};
   endfunction

   function automatic acl_req_t random_item(int scan_len);
      acl_req_t     t;
      logic [191:0] raw;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 18) return rand_rule(6'($urandom_range(0, MAX_RULES - 1)));
      if (r < 80 && scan_len > 0)
         return packet_from_rule(sb.rule_copy[$urandom_range(0, scan_len - 1)]);
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(acl_req_t)-1:0];
      t.operation = OP_CLASSIFY;
      return t;
   endfunction

   // Present one transaction after a gap; hold start high when no gap follows
   task automatic send_item(acl_req_t t, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= t.operation;
      req_index     <= t.index;
      req_direction <= t.direction;
      req_src_ip    <= t.src_ip;
      req_src_mask  <= t.src_mask;
      req_dst_ip    <= t.dst_ip;
      req_dst_mask  <= t.dst_mask;
      req_protocol  <= t.protocol;
      req_src_port  <= t.l4_src;
      req_dst_port  <= t.l4_dst;
      req_ack       <= t.ack;
      req_action    <= t.action;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(t);
   endtask

   // Drop start and wait until every response has come back
   task automatic drain();
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register, then read it back
   task automatic csr_write(logic reg_idx, logic [31:0] data);
      logic [31:0] stored;
      stored = (reg_idx == REG_TABLE_ACTIVE) ? (data & 32'h1) : (data & 32'h7F);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.set_register(reg_idx, data);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== stored)
         sb.flag($sformatf("register %0d read back %0h, expected %0h", reg_idx, prdata, stored));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program both registers, sometimes with junk in the unused data bits
   task automatic program_table(logic act, logic [6:0] cnt);
      logic [31:0] junk;
      junk = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
      csr_write(REG_TABLE_ACTIVE, {junk[31:1], act});
      csr_write(REG_RULE_COUNT, {junk[31:7], cnt});
      settings_seen++;
   endtask

   initial begin
      acl_req_t   hit0;
      logic       set_act[8];
      logic [6:0] set_cnt[8];
      logic       act;
      logic [6:0] cnt;
      int         done_items;
      int         phase;
      bit         quiet;

      set_act = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      set_cnt = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd0, 7'd64, 7'd2};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Table off after reset: every header is accepted
      send_item(mk_pkt(DIR_IN, 32'h0, 32'h0, PROTO_ICMP, 16'h0, 16'h0, ACK_CLEAR), 0);
      send_item(mk_pkt(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_ANY,
                       16'hFFFF, 16'hFFFF, 2'd3), 0);

      // Fill every slot so no scan reads an unwritten entry
      for (int i = 0; i < MAX_RULES; i++) send_item(rand_rule(6'(i)), pick_gap(1'b0));

      // Directed rules in the first four slots
      send_item(mk_rule(6'd0, DIR_IN, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0101,
                        32'hFFFF_FFFF, PROTO_TCP, PORT_HIGH, 16'd80, ACK_SET, ACT_ACCEPT), 0);
      send_item(mk_rule(6'd1, DIR_ANY, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, PROTO_UDP,
                        PORT_ANY, 16'd53, ACK_CLEAR, ACT_DROP), 0);
      send_item(mk_rule(6'd2, DIR_OUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
                        PROTO_ICMP, 16'hFFFF, 16'd1, ACK_SET, ACT_ACCEPT), 0);
      send_item(mk_rule(6'd3, DIR_ANY, 32'h0, 32'h0, 32'h0, 32'h0, PROTO_ANY,
                        16'hFFFF, 16'hFFFF, ACK_ANY, ACT_ACCEPT), 0);
      drain();
      program_table(1'b1, 7'd4);

      // Port above 1023, port equal to 1023, port and ack misses
      hit0 = mk_pkt(DIR_IN, 32'h0A12_3456, 32'hC0A8_0101, PROTO_TCP, 16'd1024, 16'd80,
                    ACK_SET);
      send_item(hit0, 0);
      send_item(mk_pkt(DIR_IN, 32'h0A00_0001, 32'hC0A8_0101, PROTO_TCP, PORT_HIGH,
                       16'd80, ACK_SET), 0);
      send_item(mk_pkt(DIR_IN, 32'h0AFF_FFFF, 32'hC0A8_0101, PROTO_TCP, 16'd1000,
                       16'd80, ACK_SET), 0);
      send_item(mk_pkt(DIR_IN, 32'h0A12_3456, 32'hC0A8_0101, PROTO_TCP, 16'd1024,
                       16'd80, ACK_CLEAR), 0);
      // UDP ignores ack, ICMP ignores ports, protocol any catches ICMP
      send_item(mk_pkt(DIR_OUT, 32'h1234_5678, 32'h0, PROTO_UDP, 16'd7, 16'd53, 2'd3), 0);
      send_item(mk_pkt(DIR_OUT, 32'hFFFF_FFFF, 32'h0, PROTO_ICMP, 16'h0, 16'h0,
                       ACK_CLEAR), 0);
      send_item(mk_pkt(DIR_IN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_ICMP, 16'h5, 16'h5,
                       ACK_SET), 0);
      // Rule-only codes in a header are compared literally
      send_item(mk_pkt(2'd3, 32'h0, 32'h0, PROTO_ANY, 16'hFFFF, 16'hFFFF, 2'd3), 0);
      send_item(mk_pkt(DIR_ANY, 32'h0A12_3456, 32'hC0A8_0101, PROTO_TCP, 16'd1024,
                       16'd80, ACK_SET), 0);
      send_item(mk_pkt(DIR_IN, 32'h0A12_3456, 32'hC0A8_0101, PROTO_ANY, 16'h0, 16'h0,
                       ACK_ANY), 0);
      // Zero rule count, oversized rule count, table switched off
      drain();
      program_table(1'b1, 7'd0);
      send_item(hit0, 0);
      drain();
      program_table(1'b1, 7'd127);
      send_item(hit0, 0);
      drain();
      program_table(1'b0, 7'd4);
      send_item(hit0, 0);

      // Random phases, each under its own register setting
      done_items = 0;
      phase      = 0;
      while (done_items < RANDOM_ITEMS) begin
         if (phase < 8) begin
            act = set_act[phase];
            cnt = set_cnt[phase];
         end else begin
            act = ($urandom_range(0, 5) != 0);
            cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(13, 127))
                                               : 7'($urandom_range(1, 12));
         end
         drain();
         program_table(act, cnt);
         quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_ITEMS && done_items < RANDOM_ITEMS; k++) begin
            send_item(random_item((cnt > MAX_RULES) ? MAX_RULES : cnt), pick_gap(quiet));
            done_items++;
         end
         phase++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.flag($sformatf("%0d responses never arrived", sb.outstanding()));

      $display("Covered %0d rule writes and %0d classifications over %0d register settings",
               sb.n_write, sb.n_classify, settings_seen);
      $display("Classifications: %0d first-match hits, %0d misses, %0d with table off",
               sb.n_hit, sb.n_miss, sb.n_inactive);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
